>>> sv/lecrl_pkg.sv
// Package for the line-evicting character ring log: widths, codes and sequencer states.
package lecrl_pkg;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int START_W = 7;

    // Parameter defaults
    localparam int DEPTH_DEF = 128;
    localparam int ROWS_DEF  = 20;

    // Byte that ends a line; it is stored as zero
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    // Command codes
    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_LIST = 1'b1
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRD,
        S_PCHK,
        S_PWR,
        S_LRD,
        S_LCHK,
        S_EMIT
    } t_state;

endpackage

>>> sv/lecrl_ifs.sv
// Valid/ready channel interfaces for the input items and the row results.
interface lecrl_in_if import lecrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface lecrl_out_if import lecrl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] line_start;
    logic               line_valid;
    logic               last;

    modport source (output valid, output row, output line_start, output line_valid,
                    output last, input ready);
    modport sink   (input valid, input row, input line_start, input line_valid,
                    input last, output ready);
endinterface

>>> sv/line_evicting_char_ring_log_unit.sv
// Line-evicting character ring log: one sequencer walks the ring with a shared step unit.
// Put: accept, then write (S_PWR); when the full ring drops its oldest line, each byte walked
//   takes a read (S_PRD) and a check (S_PCHK), since the byte store has one registered read.
// List: accept, then a read (S_LRD) and a check (S_LCHK) per byte walked backward, and a row
//   beat from S_EMIT per row (ROWS beats), held while the result side holds ready low; input waits until it is done.
// Reset (synchronous, active low) empties the ring and clears all entry valid bits at once.
module line_evicting_char_ring_log_unit import lecrl_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int ROWS  = ROWS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lecrl_in_if.sink    i_in,
    lecrl_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(ROWS + 1);

    // Ring step unit
    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_widx, n_widx;
    logic [AW-1:0]      r_ridx, n_ridx;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [AW-1:0]      r_em_start, n_em_start;
    logic               r_em_valid, n_em_valid;
    logic               r_cont, n_cont;

    logic               r_out_valid, n_out_valid;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [START_W-1:0] r_out_start, n_out_start;
    logic               r_out_lvalid, n_out_lvalid;
    logic               r_out_last, n_out_last;

    logic [CHAR_W-1:0]  r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [CHAR_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    logic [AW-1:0]      rd_addr;
    logic               rd_zero;
    logic               in_acc;
    logic               out_free;
    logic               wr_en;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign wr_en    = (r_state == S_PWR);
    assign rd_zero  = !r_rd_vld || (r_rd_data == '0);
    assign rd_addr  = (r_state == S_LRD) ? ring_prev(r_ptr) : r_ptr;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.row        = r_out_row;
    assign o_out.line_start = r_out_start;
    assign o_out.line_valid = r_out_lvalid;
    assign o_out.last       = r_out_last;

    // Byte store and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_widx] <= r_char;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_widx] <= 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_ridx      <= n_ridx;
            r_out_valid <= n_out_valid;
        end
    end

    // Work and payload registers
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_cnt        <= n_cnt;
        r_char       <= n_char;
        r_em_start   <= n_em_start;
        r_em_valid   <= n_em_valid;
        r_cont       <= n_cont;
        r_out_row    <= n_out_row;
        r_out_start  <= n_out_start;
        r_out_lvalid <= n_out_lvalid;
        r_out_last   <= n_out_last;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_widx       = r_widx;
        n_ridx       = r_ridx;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_char       = r_char;
        n_em_start   = r_em_start;
        n_em_valid   = r_em_valid;
        n_cont       = r_cont;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_row    = r_out_row;
        n_out_start  = r_out_start;
        n_out_lvalid = r_out_lvalid;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.cmd == CMD_PUT) begin
                        n_char  = (i_in.char_in == NEWLINE_CHAR) ? '0 : i_in.char_in;
                        n_ptr   = r_ridx;
                        n_state = (r_ridx == ring_next(r_widx)) ? S_PRD : S_PWR;
                    end else begin
                        n_cnt = '0;
                        if (r_widx == r_ridx) begin
                            // empty ring: all rows unused
                            n_em_valid = 1'b0;
                            n_em_start = '0;
                            n_cont     = 1'b0;
                            n_state    = S_EMIT;
                        end else begin
                            n_ptr   = ring_prev(r_widx);
                            n_state = S_LRD;
                        end
                    end
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                // drop the oldest line, stopping at the write slot
                if (r_ptr == r_widx) begin
                    n_ridx  = r_widx;
                    n_state = S_PWR;
                end else if (rd_zero) begin
                    n_ridx  = ring_next(r_ptr);
                    n_state = S_PWR;
                end else begin
                    n_ptr   = ring_next(r_ptr);
                    n_state = S_PRD;
                end
            end
            S_PWR: begin
                n_widx  = ring_next(r_widx);
                n_state = S_IDLE;
            end
            S_LRD: begin
                n_state = S_LCHK;
            end
            S_LCHK: begin
                // walk back: a zero before the pointer marks a line start
                if (r_ptr == r_ridx) begin
                    n_em_start = r_ptr;
                    n_em_valid = 1'b1;
                    n_cont     = 1'b0;
                    n_state    = S_EMIT;
                end else if (!rd_zero) begin
                    n_ptr   = ring_prev(r_ptr);
                    n_state = S_LRD;
                end else begin
                    n_em_start = r_ptr;
                    n_em_valid = 1'b1;
                    n_cont     = 1'b1;
                    n_ptr      = ring_prev(r_ptr);
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = ROW_W'(r_cnt);
                    n_out_start  = r_em_valid ? START_W'(r_em_start) : '0;
                    n_out_lvalid = r_em_valid;
                    n_out_last   = (r_cnt == CW'(ROWS - 1));
                    n_cnt        = r_cnt + 1'b1;
                    if (r_cnt == CW'(ROWS - 1)) begin
                        n_state = S_IDLE;
                    end else if (r_cont) begin
                        n_state = S_LRD;
                    end else begin
                        // pad the remaining rows
                        n_em_valid = 1'b0;
                        n_em_start = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A completed put always leaves the ring non-empty
    a_put_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWR) |=> (r_widx != r_ridx))
        else $error("ring empty after put");

    // The final beat of a list carries the last row number
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.row == ROW_W'(ROWS - 1)))
        else $error("last flag on wrong row");

    // Unused rows report start index zero
    a_unused_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.line_valid) |-> (o_out.line_start == '0))
        else $error("unused row with nonzero start");

    // No input beat is taken while a list beat is still being produced
    a_busy_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_in.ready)
        else $error("input ready during list");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the line-evicting character ring log unit.
module testbench;
    import lecrl_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int CLK_PERIOD  = 8;
    localparam int RST_CYCLES  = 9;
    localparam int RAND_ITEMS  = 330;
    localparam int QUIET_TAIL  = 60;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_MAX    = 141;

    // One row beat as seen on the result channel
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [START_W-1:0] line_start;
        logic               line_valid;
        logic               last;
    } t_row_beat;

    // Ring predictor plus the queue of row beats it expects
    class line_log_scoreboard;
        logic [CHAR_W-1:0] char_ring [DEPTH];
        int unsigned       wr_idx;
        int unsigned       rd_idx;
        t_row_beat         expected_rows [$];
        int                errors;
        int                drops;
        int                drops_unterminated;

        function new();
            foreach (char_ring[k]) char_ring[k] = '0;
            wr_idx = 0;
            rd_idx = 0;
            errors = 0;
            drops = 0;
            drops_unterminated = 0;
        endfunction

        function int unsigned step_fwd(int unsigned p);
            return (p + 1 >= DEPTH) ? 0 : p + 1;
        endfunction

        function int unsigned step_back(int unsigned p);
            return (p == 0) ? DEPTH - 1 : p - 1;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        function void push_row(int k, int unsigned start, bit valid);
            t_row_beat b;
            b.row        = k[ROW_W-1:0];
            b.line_start = valid ? start[START_W-1:0] : '0;
            b.line_valid = valid;
            b.last       = (k == ROWS - 1);
            expected_rows.push_back(b);
        endfunction

        // Store one byte; a full ring first drops its oldest line
        function void predict_put(logic [CHAR_W-1:0] ch);
            int unsigned nxt;
            int unsigned r;
            int          n;
            bit          hit;
            nxt = step_fwd(wr_idx);
            if (rd_idx == nxt) begin
                r = rd_idx;
                hit = 1'b0;
                for (n = 0; n < DEPTH; n++) begin
                    if (r == wr_idx) begin
                        hit = 1'b1;
                        break;
                    end
                    if (char_ring[r] == '0) break;
                    r = step_fwd(r);
                end
                rd_idx = hit ? wr_idx : step_fwd(r);
                drops++;
                if (hit) drops_unterminated++;
            end
            char_ring[wr_idx] = (ch == NEWLINE_CHAR) ? '0 : ch;
            wr_idx = nxt;
        endfunction

        // Backward walk from the newest byte, newest line first
        function void predict_list();
            int          i;
            int unsigned w;
            int unsigned pw;
            int unsigned guard;
            bit          at_read;
            i = 0;
            if (wr_idx != rd_idx) begin
                w = step_back(wr_idx);
                pw = step_back(w);
                guard = 0;
                while (i < ROWS && guard <= DEPTH) begin
                    at_read = 1'b0;
                    while (char_ring[pw] != '0 && guard <= DEPTH) begin
                        if (w == rd_idx) begin
                            at_read = 1'b1;
                            break;
                        end
                        w = pw;
                        pw = step_back(w);
                        guard++;
                    end
                    if (w == rd_idx) at_read = 1'b1;
                    push_row(i, at_read ? rd_idx : w, 1'b1);
                    i++;
                    if (at_read) break;
                    w = pw;
                    pw = step_back(w);
                    guard++;
                end
            end
            for (; i < ROWS; i++) push_row(i, 0, 1'b0);
        endfunction

        function void note_input(t_cmd c, logic [CHAR_W-1:0] ch);
            if (c == CMD_PUT) predict_put(ch);
            else predict_list();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_result(t_row_beat got);
            t_row_beat exp;
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row beat row=%0d start=%0d valid=%0b",
                                          got.row, got.line_start, got.line_valid));
                return;
            end
            exp = expected_rows.pop_front();
            if (got.row !== exp.row)
                report_mismatch($sformatf("row got %0d exp %0d", got.row, exp.row));
            if (got.line_start !== exp.line_start)
                report_mismatch($sformatf("row %0d line_start got %0d exp %0d",
                                          exp.row, got.line_start, exp.line_start));
            if (got.line_valid !== exp.line_valid)
                report_mismatch($sformatf("row %0d line_valid got %0b exp %0b",
                                          exp.row, got.line_valid, exp.line_valid));
            if (got.last !== exp.last)
                report_mismatch($sformatf("row %0d last got %0b exp %0b",
                                          exp.row, got.last, exp.last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    lecrl_in_if  in_ch ();
    lecrl_out_if out_ch ();

    line_evicting_char_ring_log_unit #(
        .DEPTH (DEPTH),
        .ROWS  (ROWS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    line_log_scoreboard sb;
    bit        no_idle = 1'b0;
    int        gap_odds = 4;
    int        ready_hold = 0;
    int        idle_cycles = 0;
    int        n_puts = 0;
    int        n_lists = 0;
    int        beats_checked = 0;
    t_row_beat got_beat;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side: check accepted beats, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_beat.row        = out_ch.row;
            got_beat.line_start = out_ch.line_start;
            got_beat.line_valid = out_ch.line_valid;
            got_beat.last       = out_ch.last;
            sb.check_result(got_beat);
            beats_checked++;
        end
        if (no_idle) begin
            out_ch.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            out_ch.ready <= 1'b0;
            ready_hold = $urandom_range(1, 13) - 1;
        end else begin
            out_ch.ready <= 1'b1;
            ready_hold = $urandom_range(1, 30) - 1;
        end
    end

    // Watchdog: too many cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no beat for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one item and hold it until it is accepted
    task automatic send_item(t_cmd c, logic [CHAR_W-1:0] ch);
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= c;
        in_ch.char_in <= ch;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_input(c, ch);
        if (c == CMD_PUT) n_puts++;
        else n_lists++;
    endtask

    // Random sender gap after a beat
    task automatic sender_gap();
        if (!no_idle && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_ch.valid   <= 1'b0;
            in_ch.cmd     <= t_cmd'($urandom_range(0, 1));
            in_ch.char_in <= CHAR_W'($urandom_range(0, 255));
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic put_gap(logic [CHAR_W-1:0] ch);
        send_item(CMD_PUT, ch);
        sender_gap();
    endtask

    task automatic list_gap();
        send_item(CMD_LIST, '0);
        sender_gap();
    endtask

    // Stop sending until every expected row has come back
    task automatic drain_rows();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Any byte that does not end a line
    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        b = CHAR_W'($urandom_range(1, 255));
        if (b == NEWLINE_CHAR) b = 8'h0B;
        return b;
    endfunction

    initial begin
        int n_sent;
        int kind;
        int len;
        int k;
        sb = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_PUT;
        in_ch.char_in = '0;
        out_ch.ready  = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty ring, partial line, both terminators, byte extremes
        list_gap();
        put_gap(8'h48);
        put_gap(8'hFF);
        list_gap();
        put_gap(NEWLINE_CHAR);
        put_gap(8'h00);
        put_gap(8'h01);
        put_gap(8'h80);
        put_gap(8'h7F);
        put_gap(NEWLINE_CHAR);
        list_gap();
        put_gap(8'h55);
        put_gap(8'hAA);
        put_gap(NEWLINE_CHAR);
        put_gap(NEWLINE_CHAR);
        list_gap();
        drain_rows();

        // Random: mostly short terminated lines, some noise, rare long lines.
        // The first segment is a line longer than the ring so that a drop
        // finds no terminator.
        n_sent = 0;
        kind = 0;
        while (n_sent < RAND_ITEMS) begin
            if (n_sent >= RAND_ITEMS - QUIET_TAIL) no_idle = 1'b1;
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
            // a long line only where it still fits in the item budget
            if (kind == 0 && n_sent + LONG_MAX > RAND_ITEMS) kind = 2;
            if (kind == 0) begin
                len = (n_sent == 0) ? 140 : $urandom_range(125, 140);
                for (k = 0; k < len; k++) put_gap(text_byte());
                n_sent += len;
                list_gap();
                n_sent++;
            end else if (kind == 1) begin
                // noise: any byte values, then a listing
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) put_gap(CHAR_W'($urandom_range(0, 255)));
                n_sent += len;
                list_gap();
                n_sent++;
            end else begin
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++) put_gap(text_byte());
                n_sent += len;
                if ($urandom_range(0, 5) != 0) begin
                    put_gap(($urandom_range(0, 3) == 0) ? 8'h00 : NEWLINE_CHAR);
                    n_sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    list_gap();
                    n_sent++;
                end
            end
            kind = ($urandom_range(0, 14) == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 1 : 2);
        end
        list_gap();

        // Wind down: wait out the results and any walk still in progress
        drain_rows();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected row beats never arrived",
                                         sb.pending()));

        $display("Ran %0d puts and %0d listings, %0d row beats compared.",
                 n_puts, n_lists, beats_checked);
        $display("Ring dropped %0d oldest lines, %0d of them with no terminator found.",
                 sb.drops, sb.drops_unterminated);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
